@@ rtl/wsr_pkg.sv @@
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants for the window slot recenter unit: item
// payloads, command codes, and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wsr_pkg;

    // fixed widths of the item fields and offset digits
    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 5;
    localparam int DIG_BITS   = 2;

    // command codes
    localparam logic CMD_PLACE    = 1'b0;
    localparam logic CMD_RECENTER = 1'b1;

    // input item
    typedef struct packed {
        logic                          command;
        logic signed [FIELD_BITS-1:0]  center_x;
        logic signed [FIELD_BITS-1:0]  center_y;
        logic signed [FIELD_BITS-1:0]  center_z;
    } t_wsr_in;

    // result item
    typedef struct packed {
        logic [SLOT_BITS-1:0]          slot;
        logic signed [FIELD_BITS-1:0]  cell_x;
        logic signed [FIELD_BITS-1:0]  cell_y;
        logic signed [FIELD_BITS-1:0]  cell_z;
        logic                          last;
    } t_wsr_out;

    // controller to datapath
    typedef struct packed {
        logic                 load_in;    // capture accepted item
        logic                 set_center; // commit new center, mark placed
        logic                 clr_flags;  // open a recenter sweep
        logic                 rd_en;      // read slot store at j_slot
        logic                 cmp_en;     // read data valid for cmp_slot
        logic                 emit;       // write slot store and load output
        logic                 emit_last;
        logic [SLOT_BITS-1:0] oi;         // current offset index
        logic [DIG_BITS-1:0]  dx;
        logic [DIG_BITS-1:0]  dy;
        logic [DIG_BITS-1:0]  dz;
        logic [SLOT_BITS-1:0] j_slot;     // slot being read or scanned
        logic [SLOT_BITS-1:0] cmp_slot;   // slot whose data is compared
        logic [SLOT_BITS-1:0] wr_slot;    // slot given a new cell
    } t_wsr_cmd;

    // datapath to controller
    typedef struct packed {
        logic                 recenter;    // recenter on a placed cube
        logic                 same_center;
        logic                 radius;      // effective radius
        logic [SLOT_BITS-1:0] n_last;      // highest slot index in use
        logic                 match;       // read data equals offset cell
        logic                 off_unm;     // current offset has no slot
        logic                 slot_stale;  // scanned slot is free
        logic                 last_unm;    // current offset is the final unmatched one
        logic                 out_ready;
    } t_wsr_sts;

endpackage

`default_nettype wire

@@ rtl/wsr_ram.sv @@
// ----------------------------------------------------------------------------
// wsr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 27,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/wsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsr_ctrl
// Sequencer for place and recenter: walks the offsets, runs the match sweep
// over the slot store and the stale slot scan, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire wsr_pkg::t_wsr_sts i_sts,
    output wsr_pkg::t_wsr_cmd      o_cmd
);

    import wsr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_PLACE  = 3'd2;
    localparam logic [2:0] ST_MATCH  = 3'd3;
    localparam logic [2:0] ST_ASSIGN = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [SLOT_BITS-1:0] r_oi, n_oi;
    logic [DIG_BITS-1:0]  r_dx, n_dx;
    logic [DIG_BITS-1:0]  r_dy, n_dy;
    logic [DIG_BITS-1:0]  r_dz, n_dz;
    logic [SLOT_BITS-1:0] r_j, n_j;
    logic                 r_cv, n_cv;
    logic [SLOT_BITS-1:0] r_cj, n_cj;

    // offset walk: z innermost, then y, then x
    logic [DIG_BITS-1:0]  dig_max;
    logic [SLOT_BITS-1:0] adv_oi;
    logic [DIG_BITS-1:0]  adv_dx, adv_dy, adv_dz;
    logic                 offset_last;
    logic                 done_off;

    assign dig_max     = {i_sts.radius, 1'b0};
    assign offset_last = (r_oi == i_sts.n_last);
    assign adv_oi      = r_oi + SLOT_BITS'(1);

    always_comb begin
        adv_dx = r_dx;
        adv_dy = r_dy;
        adv_dz = r_dz + DIG_BITS'(1);
        if (r_dz == dig_max) begin
            adv_dz = '0;
            adv_dy = r_dy + DIG_BITS'(1);
            if (r_dy == dig_max) begin
                adv_dy = '0;
                adv_dx = r_dx + DIG_BITS'(1);
            end
        end
    end

    // an offset's match search ends on a hit or after its final slot
    assign done_off = r_cv && (i_sts.match || (r_cj == i_sts.n_last));

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_oi    = r_oi;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_dz    = r_dz;
        n_j     = r_j;
        n_cv    = r_cv;
        n_cj    = r_cj;

        o_cmd          = '0;
        o_cmd.oi       = r_oi;
        o_cmd.dx       = r_dx;
        o_cmd.dy       = r_dy;
        o_cmd.dz       = r_dz;
        o_cmd.j_slot   = r_j;
        o_cmd.cmp_slot = r_cj;
        o_cmd.wr_slot  = r_oi;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_oi = '0;
                n_dx = '0;
                n_dy = '0;
                n_dz = '0;
                n_j  = '0;
                n_cv = 1'b0;
                if (!i_sts.recenter) begin
                    o_cmd.set_center = 1'b1;
                    n_state          = ST_PLACE;
                end else if (i_sts.same_center) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.set_center = 1'b1;
                    o_cmd.clr_flags  = 1'b1;
                    n_state          = ST_MATCH;
                end
            end
            ST_PLACE: begin
                if (i_sts.out_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = offset_last;
                    n_oi = adv_oi;
                    n_dx = adv_dx;
                    n_dy = adv_dy;
                    n_dz = adv_dz;
                    if (offset_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MATCH: begin
                o_cmd.cmp_en = r_cv;
                if (done_off) begin
                    n_j  = '0;
                    n_cv = 1'b0;
                    if (offset_last) begin
                        n_oi    = '0;
                        n_dx    = '0;
                        n_dy    = '0;
                        n_dz    = '0;
                        n_state = ST_ASSIGN;
                    end else begin
                        n_oi = adv_oi;
                        n_dx = adv_dx;
                        n_dy = adv_dy;
                        n_dz = adv_dz;
                    end
                end else if (r_j <= i_sts.n_last) begin
                    o_cmd.rd_en = 1'b1;
                    n_cv = 1'b1;
                    n_cj = r_j;
                    n_j  = r_j + SLOT_BITS'(1);
                end else begin
                    n_cv = 1'b0;
                end
            end
            ST_ASSIGN: begin
                // stale slots are taken in rising order, so j never rewinds
                if (!i_sts.off_unm) begin
                    n_oi = adv_oi;
                    n_dx = adv_dx;
                    n_dy = adv_dy;
                    n_dz = adv_dz;
                    if (offset_last) begin
                        n_state = ST_IDLE;
                    end
                end else if (!i_sts.slot_stale) begin
                    n_j = r_j + SLOT_BITS'(1);
                end else if (i_sts.out_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = i_sts.last_unm;
                    o_cmd.wr_slot   = r_j;
                    n_j  = r_j + SLOT_BITS'(1);
                    n_oi = adv_oi;
                    n_dx = adv_dx;
                    n_dy = adv_dy;
                    n_dz = adv_dz;
                    if (offset_last || i_sts.last_unm) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // input held off during reset and while an item is in progress
    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oi    <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_dz    <= '0;
            r_j     <= '0;
            r_cv    <= 1'b0;
            r_cj    <= '0;
        end else begin
            r_state <= n_state;
            r_oi    <= n_oi;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_dz    <= n_dz;
            r_j     <= n_j;
            r_cv    <= n_cv;
            r_cj    <= n_cj;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wsr_dp.sv @@
// ----------------------------------------------------------------------------
// wsr_dp
// Datapath: radius and center registers, offset cell adder, slot store,
// match comparator, sweep flags and the output item register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_dp #(
    parameter int MAX_RADIUS = 1,
    parameter int COORD_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsr_pkg::t_wsr_in  i_in_data,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire wsr_pkg::t_wsr_cmd i_cmd,
    output wsr_pkg::t_wsr_sts      o_sts,
    output logic                   o_out_valid,
    output wsr_pkg::t_wsr_out      o_out_data,
    input  wire logic              i_out_stall
);

    import wsr_pkg::*;

    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int NSLOT = SIDE * SIDE * SIDE;
    localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CB    = COORD_BITS;

    logic                 r_radius;
    logic                 r_placed;
    logic                 r_ncmd;
    logic signed [CB-1:0] r_cx, r_cy, r_cz;
    logic signed [CB-1:0] r_nx, r_ny, r_nz;
    logic [NSLOT-1:0]     r_unm, n_unm;
    logic [NSLOT-1:0]     r_stale, n_stale;
    logic                 r_out_valid;
    t_wsr_out             r_out;

    logic                 eff_r;
    logic [SLOT_BITS-1:0] n_last;
    logic signed [CB-1:0] cell_x, cell_y, cell_z;
    logic [3*CB-1:0]      rdata;
    logic                 match;
    logic                 out_ready;
    logic [NSLOT-1:0]     oi_mask;
    logic [AW-1:0]        oi_a;

    assign eff_r  = (MAX_RADIUS != 0) ? r_radius : 1'b0;
    assign n_last = eff_r ? SLOT_BITS'(NSLOT - 1) : '0;
    assign oi_a   = i_cmd.oi[AW-1:0];

    // configuration and placed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 1'b1;
            r_placed <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
            r_placed <= 1'b0;
        end else if (i_cmd.set_center) begin
            r_placed <= 1'b1;
        end
    end

    // captured item, wrapped to coordinate width
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ncmd <= i_in_data.command;
            r_nx   <= CB'(32'(i_in_data.center_x));
            r_ny   <= CB'(32'(i_in_data.center_y));
            r_nz   <= CB'(32'(i_in_data.center_z));
        end
    end

    // current center
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end else if (i_cmd.set_center) begin
            r_cx <= r_nx;
            r_cy <= r_ny;
            r_cz <= r_nz;
        end
    end

    // cell of the current offset around the current center
    assign cell_x = r_cx + CB'(i_cmd.dx) - CB'(eff_r);
    assign cell_y = r_cy + CB'(i_cmd.dy) - CB'(eff_r);
    assign cell_z = r_cz + CB'(i_cmd.dz) - CB'(eff_r);

    // slot store
    wsr_ram #(
        .WIDTH (3 * CB),
        .DEPTH (NSLOT),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit),
        .i_waddr (i_cmd.wr_slot[AW-1:0]),
        .i_wdata ({cell_x, cell_y, cell_z}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.j_slot[AW-1:0]),
        .o_rdata (rdata)
    );

    assign match = (rdata == {cell_x, cell_y, cell_z});

    // sweep flags: unmatched offsets and stale slots
    always_comb begin
        oi_mask = '0;
        oi_mask[oi_a] = 1'b1;
    end

    always_comb begin
        n_unm   = r_unm;
        n_stale = r_stale;
        if (i_cmd.clr_flags) begin
            for (int k = 0; k < NSLOT; k++) begin
                n_unm[k]   = (SLOT_BITS'(k) <= n_last);
                n_stale[k] = (SLOT_BITS'(k) <= n_last);
            end
        end else if ((i_cmd.cmp_en && match) || i_cmd.emit) begin
            n_unm[oi_a] = 1'b0;
            if (i_cmd.emit) begin
                n_stale[i_cmd.wr_slot[AW-1:0]] = 1'b0;
            end else begin
                n_stale[i_cmd.cmp_slot[AW-1:0]] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unm   <= '0;
            r_stale <= '0;
        end else begin
            r_unm   <= n_unm;
            r_stale <= n_stale;
        end
    end

    // output item register
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.slot   <= i_cmd.wr_slot;
            r_out.cell_x <= FIELD_BITS'(32'(cell_x));
            r_out.cell_y <= FIELD_BITS'(32'(cell_y));
            r_out.cell_z <= FIELD_BITS'(32'(cell_z));
            r_out.last   <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status back to the controller
    assign o_sts.recenter    = (r_ncmd == CMD_RECENTER) && r_placed;
    assign o_sts.same_center = (r_nx == r_cx) && (r_ny == r_cy) && (r_nz == r_cz);
    assign o_sts.radius      = eff_r;
    assign o_sts.n_last      = n_last;
    assign o_sts.match       = match;
    assign o_sts.off_unm     = r_unm[oi_a];
    assign o_sts.slot_stale  = r_stale[i_cmd.j_slot[AW-1:0]];
    assign o_sts.last_unm    = ((r_unm & ~oi_mask) == '0);
    assign o_sts.out_ready   = out_ready;

endmodule

`default_nettype wire

@@ rtl/window_slot_recenter_unit.sv @@
// Place: an accepted item goes through the decide state, then one slot is emitted per cycle
// into the output register while the output is not stalled, (2r+1)^3 slots in all.
// Recenter: a match sweep over the n slots (one slot store read per cycle), then a
// stale slot scan that gives each unmatched offset a free slot.
// One item at a time: the input stalls from acceptance until the last result is issued, or the item ends with none.
// Reset (synchronous): input stalled, radius 1, nothing placed, output empty, store undefined.
// ----------------------------------------------------------------------------
// window_slot_recenter_unit
// Cube of slots around a center cell; places all slots or reassigns the
// slots whose cells fall out of the cube when the center moves.
// ----------------------------------------------------------------------------
`default_nettype none

module window_slot_recenter_unit #(
    parameter int MAX_RADIUS = 1,
    parameter int COORD_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire wsr_pkg::t_wsr_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output wsr_pkg::t_wsr_out      o_out_data,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data
);

    import wsr_pkg::*;

    t_wsr_cmd cmd;
    t_wsr_sts sts;

    // sequencer
    wsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    wsr_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire
